FILE: rtl/fpc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package fpc_pkg;

  localparam int FPC_OPERAND_WIDTH = 32;
  localparam int FPC_FRAC_BITS     = 16;
  localparam int CFG_DATA_W        = 16;
  localparam int TOL_W             = 16;
  localparam int LIMIT_W           = 10;
  localparam logic [TOL_W-1:0]   TOL_RESET   = TOL_W'(1);
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(64);

  typedef enum logic {
    CFG_TOLERANCE  = 1'b0,
    CFG_ITER_LIMIT = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ACT_ADD   = 3'd0,
    ACT_SUB   = 3'd1,
    ACT_MUL   = 3'd2,
    ACT_DIV   = 3'd3,
    ACT_POW   = 3'd4,
    ACT_ROOT  = 3'd5
  } action_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_DIV0    = 3'd1,
    ST_NEGROOT = 3'd2,
    ST_SAT     = 3'd3,
    ST_NOCONV  = 3'd4
  } status_t;

  typedef enum logic [4:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_ADDSUB,
    CMD_MUL_START,
    CMD_MUL_END,
    CMD_DIV_ZERO,
    CMD_DIV_AB,
    CMD_DIV_STEP,
    CMD_DIV_END,
    CMD_POW_INIT_A,
    CMD_POW_INIT_X,
    CMD_POW_MUL,
    CMD_POW_CHK,
    CMD_POW_END,
    CMD_ROOT_ONE,
    CMD_ROOT_NEG,
    CMD_ROOT_INIT,
    CMD_ROOT_NOCONV,
    CMD_ROOT_Q,
    CMD_ROOT_QEND,
    CMD_ROOT_MUL,
    CMD_ROOT_T,
    CMD_ROOT_NEXT,
    CMD_BAD
  } cmd_op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_MUL_END,
    S_DIV_RUN,
    S_DIV_END,
    S_POW_LOOP,
    S_POW_CHK,
    S_POW_END,
    S_ROOT_TOP,
    S_ROOT_Q,
    S_ROOT_QEND,
    S_ROOT_MUL,
    S_ROOT_T,
    S_ROOT_NEXT,
    S_OUT
  } ctl_state_t;

  typedef struct packed {
    logic [2:0] action;
    logic       b_zero;
    logic       a_neg;
    logic       cnt_zero;
    logic       r_zero;
    logic       div_done;
    logic       converged;
    logic       k_at_limit;
  } dp_sts_t;

endpackage
`default_nettype wire

FILE: rtl/fpc_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface fpc_in_if #(parameter int W = 32);
  logic                valid;
  logic                ready;
  logic [2:0]          action;
  logic signed [W-1:0] operand_a;
  logic signed [W-1:0] operand_b;
  modport source(output valid, action, operand_a, operand_b, input ready);
  modport sink(input valid, action, operand_a, operand_b, output ready);
endinterface

interface fpc_out_if #(parameter int W = 32);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] result_value;
  logic [2:0]          status;
  modport source(output valid, result_value, status, input ready);
  modport sink(input valid, result_value, status, output ready);
endinterface
`default_nettype wire

FILE: rtl/fpc_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module fpc_ctrl import fpc_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  input  dp_sts_t sts,
  output cmd_op_t cmd
);

  ctl_state_t state, state_next;
  ctl_state_t ret, ret_next;
  logic       in_root, in_root_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      ret     <= S_IDLE;
      in_root <= 1'b0;
    end else begin
      state   <= state_next;
      ret     <= ret_next;
      in_root <= in_root_next;
    end
  end

  always_comb begin
    state_next   = state;
    ret_next     = ret;
    in_root_next = in_root;
    cmd          = CMD_NONE;
    in_ready     = 1'b0;
    out_valid    = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd        = CMD_LOAD;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        priority case (sts.action)
          ACT_ADD, ACT_SUB: begin
            cmd        = CMD_ADDSUB;
            state_next = S_OUT;
          end
          ACT_MUL: begin
            cmd        = CMD_MUL_START;
            state_next = S_MUL_END;
          end
          ACT_DIV: begin
            if (sts.b_zero) begin
              cmd        = CMD_DIV_ZERO;
              state_next = S_OUT;
            end else begin
              cmd        = CMD_DIV_AB;
              ret_next   = S_DIV_END;
              state_next = S_DIV_RUN;
            end
          end
          ACT_POW: begin
            cmd          = CMD_POW_INIT_A;
            in_root_next = 1'b0;
            state_next   = S_POW_LOOP;
          end
          ACT_ROOT: begin
            if (sts.b_zero) begin
              cmd        = CMD_ROOT_ONE;
              state_next = S_OUT;
            end else if (sts.a_neg) begin
              cmd        = CMD_ROOT_NEG;
              state_next = S_OUT;
            end else begin
              cmd        = CMD_ROOT_INIT;
              state_next = S_ROOT_TOP;
            end
          end
          default: begin
            cmd        = CMD_BAD;
            state_next = S_OUT;
          end
        endcase
      end
      S_MUL_END: begin
        cmd        = CMD_MUL_END;
        state_next = S_OUT;
      end
      S_DIV_RUN: begin
        if (sts.div_done) begin
          state_next = ret;
        end else begin
          cmd = CMD_DIV_STEP;
        end
      end
      S_DIV_END: begin
        cmd        = CMD_DIV_END;
        state_next = S_OUT;
      end
      S_POW_LOOP: begin
        if (sts.cnt_zero) begin
          state_next = in_root ? S_ROOT_Q : S_POW_END;
        end else begin
          cmd        = CMD_POW_MUL;
          state_next = S_POW_CHK;
        end
      end
      S_POW_CHK: begin
        cmd        = CMD_POW_CHK;
        state_next = S_POW_LOOP;
      end
      S_POW_END: begin
        cmd        = CMD_POW_END;
        state_next = S_OUT;
      end
      S_ROOT_TOP: begin
        if (sts.k_at_limit) begin
          cmd        = CMD_ROOT_NOCONV;
          state_next = S_OUT;
        end else begin
          cmd          = CMD_POW_INIT_X;
          in_root_next = 1'b1;
          state_next   = S_POW_LOOP;
        end
      end
      S_ROOT_Q: begin
        cmd = CMD_ROOT_Q;
        if (sts.r_zero) begin
          state_next = S_ROOT_MUL;
        end else begin
          ret_next   = S_ROOT_QEND;
          state_next = S_DIV_RUN;
        end
      end
      S_ROOT_QEND: begin
        cmd        = CMD_ROOT_QEND;
        state_next = S_ROOT_MUL;
      end
      S_ROOT_MUL: begin
        cmd        = CMD_ROOT_MUL;
        state_next = S_ROOT_T;
      end
      S_ROOT_T: begin
        cmd        = CMD_ROOT_T;
        ret_next   = S_ROOT_NEXT;
        state_next = S_DIV_RUN;
      end
      S_ROOT_NEXT: begin
        cmd        = CMD_ROOT_NEXT;
        state_next = sts.converged ? S_OUT : S_ROOT_TOP;
      end
      S_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

FILE: rtl/fpc_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
module fpc_datapath import fpc_pkg::*; #(
  parameter int OPERAND_WIDTH = FPC_OPERAND_WIDTH,
  parameter int FRAC_BITS     = FPC_FRAC_BITS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  cmd_op_t                         cmd,
  output dp_sts_t                         sts,
  input  logic                            cfg_we,
  input  logic                            cfg_index,
  input  logic [CFG_DATA_W-1:0]           cfg_data,
  input  logic [2:0]                      action,
  input  logic signed [OPERAND_WIDTH-1:0] operand_a,
  input  logic signed [OPERAND_WIDTH-1:0] operand_b,
  output logic signed [OPERAND_WIDTH-1:0] result_value,
  output logic [2:0]                      status
);

  localparam int W   = OPERAND_WIDTH;
  localparam int F   = FRAC_BITS;
  localparam int MW  = W + 1;
  localparam int PW  = 2 * MW;
  localparam int QW  = W + F;
  localparam int CW  = W + 1 - F;
  localparam int DCW = $clog2(QW + 1);
  localparam logic signed [W-1:0]  ONE    = {{(W-F-1){1'b0}}, 1'b1, {F{1'b0}}};
  localparam logic signed [W-1:0]  MAXV   = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0]  MINV   = {1'b1, {(W-1){1'b0}}};
  localparam logic signed [MW-1:0] ONE_M1 = {{(MW-F){1'b0}}, {F{1'b1}}};

  logic signed [W-1:0]  a_r, b_r, res_r, x_r, base_r, r_r, q_r;
  logic signed [MW-1:0] em1_r;
  logic [2:0]           act_r;
  status_t              st_r;
  logic                 sat_r, odd_r, neg_r;
  logic [CW-1:0]        cnt_r;
  logic signed [PW-1:0] prod_r;
  logic [QW-1:0]        num_r;
  logic [W-1:0]         den_r, rem_r;
  logic [DCW-1:0]       dcnt_r;
  logic [LIMIT_W-1:0]   k_r, lim_r;
  logic [TOL_W-1:0]     tol_r;

  logic signed [PW-1:0] fl;
  logic [PW-W:0]        mul_hi;
  logic                 mul_sat;
  logic signed [W-1:0]  mul_res;
  logic                 q_ovf;
  logic signed [W-1:0]  q_res;
  logic signed [MW-1:0] ab_sum, t_sum, diff, absd;
  logic                 ab_ovf, t_ovf, converged;
  logic signed [W-1:0]  ab_res, t_res;
  logic signed [MW-1:0] pe, pe_sum;
  logic                 pe_pos;
  logic signed [MW-1:0] mul_a, mul_b;
  logic                 div_start;
  logic signed [W-1:0]  div_n, div_d;
  logic [W-1:0]         nmag, dmag;
  logic [W:0]           rem2, rem_sub;
  logic                 rem_ge;

  always_comb begin
    fl      = prod_r >>> F;
    mul_hi  = fl[PW-1:W-1];
    mul_sat = !((&mul_hi) || (~|mul_hi));
    mul_res = mul_sat ? (fl[PW-1] ? MINV : MAXV) : fl[W-1:0];

    q_ovf = neg_r ? ((|num_r[QW-1:W]) || (num_r[W-1] && (|num_r[W-2:0])))
                  : (|num_r[QW-1:W-1]);
    q_res = q_ovf ? (neg_r ? MINV : MAXV)
                  : (neg_r ? -$signed(num_r[W-1:0]) : $signed(num_r[W-1:0]));

    ab_sum = (act_r == ACT_SUB) ? ({a_r[W-1], a_r} - {b_r[W-1], b_r})
                                : ({a_r[W-1], a_r} + {b_r[W-1], b_r});
    ab_ovf = ab_sum[W] != ab_sum[W-1];
    ab_res = ab_ovf ? (ab_sum[W] ? MINV : MAXV) : ab_sum[W-1:0];

    t_sum = {mul_res[W-1], mul_res} + {q_r[W-1], q_r};
    t_ovf = t_sum[W] != t_sum[W-1];
    t_res = t_ovf ? (t_sum[W] ? MINV : MAXV) : t_sum[W-1:0];

    diff      = {q_res[W-1], q_res} - {x_r[W-1], x_r};
    absd      = diff[W] ? -diff : diff;
    converged = absd < $signed({{(MW-TOL_W){1'b0}}, tol_r});

    pe     = (cmd == CMD_POW_INIT_X) ? em1_r : {b_r[W-1], b_r};
    pe_pos = !pe[W] && (pe != '0);
    pe_sum = pe + ONE_M1;

    unique case (cmd)
      CMD_POW_MUL: begin
        mul_a = {r_r[W-1], r_r};
        mul_b = {base_r[W-1], base_r};
      end
      CMD_ROOT_MUL: begin
        mul_a = em1_r;
        mul_b = {x_r[W-1], x_r};
      end
      default: begin
        mul_a = {a_r[W-1], a_r};
        mul_b = {b_r[W-1], b_r};
      end
    endcase

    div_start = 1'b0;
    div_n     = a_r;
    div_d     = b_r;
    unique case (cmd)
      CMD_DIV_AB: begin
        div_start = 1'b1;
      end
      CMD_ROOT_Q: begin
        div_start = r_r != '0;
        div_d     = r_r;
      end
      CMD_ROOT_T: begin
        div_start = 1'b1;
        div_n     = t_res;
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
    nmag = div_n[W-1] ? W'(-div_n) : W'(div_n);
    dmag = div_d[W-1] ? W'(-div_d) : W'(div_d);

    rem2    = {rem_r, num_r[QW-1]};
    rem_ge  = rem2 >= {1'b0, den_r};
    rem_sub = rem2 - {1'b0, den_r};
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      tol_r <= TOL_RESET;
      lim_r <= LIMIT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_TOLERANCE:  tol_r <= cfg_data[TOL_W-1:0];
        CFG_ITER_LIMIT: lim_r <= cfg_data[LIMIT_W-1:0];
        default:        tol_r <= tol_r;
      endcase
    end
  end

  // shared divider
  always_ff @(posedge clk) begin
    if (rst) begin
      dcnt_r <= '0;
    end else if (div_start) begin
      num_r  <= {nmag, {F{1'b0}}};
      den_r  <= dmag;
      rem_r  <= '0;
      neg_r  <= div_n[W-1] ^ div_d[W-1];
      dcnt_r <= DCW'(QW);
    end else if (cmd == CMD_DIV_STEP) begin
      rem_r  <= rem_ge ? rem_sub[W-1:0] : rem2[W-1:0];
      num_r  <= {num_r[QW-2:0], rem_ge};
      dcnt_r <= dcnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd == CMD_MUL_START || cmd == CMD_POW_MUL || cmd == CMD_ROOT_MUL) begin
      prod_r <= mul_a * mul_b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt_r <= '0;
      k_r   <= '0;
      sat_r <= 1'b0;
    end else begin
      unique case (cmd)
        CMD_LOAD: begin
          a_r   <= operand_a;
          b_r   <= operand_b;
          act_r <= action;
          sat_r <= 1'b0;
        end
        CMD_ADDSUB: begin
          res_r <= ab_res;
          st_r  <= ab_ovf ? ST_SAT : ST_OK;
        end
        CMD_MUL_END: begin
          res_r <= mul_res;
          st_r  <= mul_sat ? ST_SAT : ST_OK;
        end
        CMD_DIV_ZERO, CMD_ROOT_ONE: begin
          res_r <= ONE;
          st_r  <= (cmd == CMD_DIV_ZERO) ? ST_DIV0 : ST_OK;
        end
        CMD_ROOT_NEG: begin
          res_r <= ONE;
          st_r  <= ST_NEGROOT;
        end
        CMD_DIV_END: begin
          res_r <= q_res;
          st_r  <= q_ovf ? ST_SAT : ST_OK;
        end
        CMD_POW_INIT_A, CMD_POW_INIT_X: begin
          base_r <= (cmd == CMD_POW_INIT_X) ? x_r : a_r;
          cnt_r  <= pe_pos ? pe_sum[W:F] : '0;
          odd_r  <= pe_pos && pe_sum[F];
          r_r    <= ONE;
        end
        CMD_POW_CHK: begin
          if (mul_sat) begin
            r_r   <= (base_r[W-1] && odd_r) ? MINV : MAXV;
            sat_r <= 1'b1;
            cnt_r <= '0;
          end else begin
            r_r   <= mul_res;
            cnt_r <= (mul_res == '0) ? '0 : cnt_r - 1'b1;
          end
        end
        CMD_POW_END: begin
          res_r <= r_r;
          st_r  <= sat_r ? ST_SAT : ST_OK;
        end
        CMD_ROOT_INIT: begin
          x_r   <= ONE;
          em1_r <= {b_r[W-1], b_r} - {ONE[W-1], ONE};
          k_r   <= '0;
        end
        CMD_ROOT_NOCONV: begin
          res_r <= x_r;
          st_r  <= ST_NOCONV;
        end
        CMD_ROOT_Q: begin
          if (r_r == '0) begin
            q_r   <= (a_r != '0) ? MAXV : '0;
            sat_r <= sat_r || (a_r != '0);
          end
        end
        CMD_ROOT_QEND: begin
          q_r   <= q_res;
          sat_r <= sat_r || q_ovf;
        end
        CMD_ROOT_T: begin
          sat_r <= sat_r || mul_sat || t_ovf;
        end
        CMD_ROOT_NEXT: begin
          if (converged) begin
            res_r <= x_r;
            st_r  <= (sat_r || q_ovf) ? ST_SAT : ST_OK;
          end else begin
            x_r   <= q_res;
            k_r   <= k_r + 1'b1;
            sat_r <= sat_r || q_ovf;
          end
        end
        CMD_BAD: begin
          res_r <= '0;
          st_r  <= ST_OK;
        end
        default: begin
          sat_r <= sat_r;
        end
      endcase
    end
  end

  assign sts.action     = act_r;
  assign sts.b_zero     = b_r == '0;
  assign sts.a_neg      = a_r[W-1];
  assign sts.cnt_zero   = cnt_r == '0;
  assign sts.r_zero     = r_r == '0;
  assign sts.div_done   = dcnt_r == '0;
  assign sts.converged  = converged;
  assign sts.k_at_limit = k_r == lim_r;

  assign result_value = res_r;
  assign status       = st_r;

`ifndef NO_ASSERTIONS
  a_div_step_busy: assert property (@(posedge clk) disable iff (rst)
    cmd == CMD_DIV_STEP |-> dcnt_r != '0)
    else $error("divider stepped after finishing");

  a_pow_chk_order: assert property (@(posedge clk) disable iff (rst)
    cmd == CMD_POW_CHK |-> $past(cmd) == CMD_POW_MUL)
    else $error("power check without a product");

  a_root_k_bound: assert property (@(posedge clk) disable iff (rst)
    cmd == CMD_ROOT_NEXT |-> k_r < lim_r)
    else $error("root iteration beyond limit");
`endif

endmodule
`default_nettype wire

FILE: rtl/fixed_point_calculator_alu.sv
`timescale 1ns / 1ps
`default_nettype none
// fixed-point calculator: add, subtract, multiply, divide, power, nth root
// input channel in_ch: action code with two signed Q operands, one
// transaction per request; output channel out_ch: one transaction per
// request carrying result_value and status
// config port: cfg_we with cfg_index 0 sets root_tolerance, 1 sets
// iteration_limit; write only while no request is in flight
// one request at a time: in_ch.ready is high only when the block is idle
// operation steps: add/sub from the dispatch state, multiply with a
// registered product, divide one quotient bit per cycle in the shared
// divider, power a multiply and a check per exponent step, root per Newton
// step a power loop, a quotient divide, a multiply and a second divide
// reset: both config registers take their defaults (tolerance 1, limit 64)
// and the controller returns to idle with no result pending
// a stalled out_ch holds the result steady and no new request is taken
module fixed_point_calculator_alu import fpc_pkg::*; #(
  parameter int OPERAND_WIDTH = FPC_OPERAND_WIDTH,
  parameter int FRAC_BITS     = FPC_FRAC_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  fpc_in_if.sink                in_ch,
  fpc_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cmd_op_t cmd;
  dp_sts_t sts;

  fpc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  fpc_datapath #(
    .OPERAND_WIDTH (OPERAND_WIDTH),
    .FRAC_BITS     (FRAC_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .action       (in_ch.action),
    .operand_a    (in_ch.operand_a),
    .operand_b    (in_ch.operand_b),
    .result_value (out_ch.result_value),
    .status       (out_ch.status)
  );

endmodule
`default_nettype wire
